// ===== hw/rtl/nbv_pkg.sv =====
// shared types, constants and helpers of the n-body verlet step block
`default_nettype none
package nbv_pkg;

    localparam int NB_MAX = 64;
    localparam int IDX_W  = $clog2(NB_MAX);
    localparam int CNT_W  = IDX_W + 1;
    localparam int ADDR_W = 4;
    localparam int DIV_BPC  = 4;
    localparam int SQRT_BPC = 2;

    localparam logic [1:0] REG_TIME_STEP  = 2'd0;
    localparam logic [1:0] REG_GRAV_CONST = 2'd1;
    localparam logic [1:0] REG_MIN_DIST   = 2'd2;

    localparam logic [31:0] TIME_STEP_RST  = 32'd1092;
    localparam logic [31:0] GRAV_CONST_RST = 32'd65536;
    localparam logic [31:0] MIN_DIST_RST   = 32'd1;

    localparam logic [62:0] MAG_CAP = 63'h4000_0000_0000_0000;

    localparam logic [4:0] MUL_LAST  = 5'd4;
    localparam logic [4:0] DIV_LAST  = 5'd19;
    localparam logic [4:0] SQRT_LAST = 5'd15;

    typedef enum logic [1:0] {
        AU_MULF,
        AU_MULQ,
        AU_DIVQ,
        AU_SQRT
    } au_op_t;

    typedef struct packed {
        logic   go;
        au_op_t op;
    } au_req_t;

    typedef struct packed {
        logic done;
    } au_rsp_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_A_RDI,
        ST_A_LDI,
        ST_A_RDJ,
        ST_A_DIFF,
        ST_A_SQX,
        ST_A_SQY,
        ST_A_SQRT,
        ST_A_GM,
        ST_A_TERM,
        ST_A_DIV,
        ST_A_ACC,
        ST_A_WR,
        ST_P_RD,
        ST_P_LD,
        ST_P_V,
        ST_P_A1,
        ST_P_A2,
        ST_P_SUM,
        ST_P_WR,
        ST_V_RD,
        ST_V_LD,
        ST_V_MUL,
        ST_V_SUM,
        ST_V_OUT
    } nbv_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sext64(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/nbody_gravity_verlet_step.sv =====
// top level: body stores, step sequencer and register port of the verlet step
// loads one body per cycle; the last body starts the step and the block is not ready after
// each acceleration pass works through the pairs one at a time on the shared arithmetic unit
// (two squares, a root, a gm multiply, per axis a multiply and three
// divides); two passes plus the update, then n result words
// synchronous active-low reset: body count cleared, registers to defaults, stores untouched
`default_nettype none
module nbody_gravity_verlet_step (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_pos_x,
    input  wire logic signed [31:0] s_pos_y,
    input  wire logic signed [31:0] s_vel_x,
    input  wire logic signed [31:0] s_vel_y,
    input  wire logic [31:0]        s_mass,
    input  wire logic               s_last_body,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [5:0]              m_body_index,
    output logic signed [31:0]      m_new_pos_x,
    output logic signed [31:0]      m_new_pos_y,
    output logic signed [31:0]      m_new_vel_x,
    output logic signed [31:0]      m_new_vel_y,
    output logic                    m_last_result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [nbv_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int IW = nbv_pkg::IDX_W;
    localparam int CW = nbv_pkg::CNT_W;

    nbv_pkg::nbv_state_t state_reg, state_next;
    logic               issued_reg, issued_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    logic               pass_reg, pass_next;
    logic               k_reg, k_next;
    logic [1:0]         dcnt_reg, dcnt_next;
    logic [31:0]        time_step_reg, grav_const_reg, min_dist_reg;

    logic signed [31:0] rp_x_reg, rp_x_next, rp_y_reg, rp_y_next;
    logic signed [31:0] rv_x_reg, rv_x_next, rv_y_reg, rv_y_next;
    logic signed [31:0] ro_x_reg, ro_x_next, ro_y_reg, ro_y_next;
    logic signed [31:0] rn_x_reg, rn_x_next, rn_y_reg, rn_y_next;
    logic signed [32:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [31:0]        mj_reg, mj_next;
    logic [63:0]        sq_reg, sq_next;
    logic [63:0]        d2_reg, d2_next;
    logic [31:0]        dist_reg, dist_next;
    logic [47:0]        gm_reg, gm_next;
    logic [62:0]        t_reg, t_next;
    logic [62:0]        u_reg, u_next;
    logic signed [31:0] accx_reg, accx_next, accy_reg, accy_next;

    logic [63:0] pos_mem  [nbv_pkg::NB_MAX];
    logic [63:0] vel_mem  [nbv_pkg::NB_MAX];
    logic [31:0] mass_mem [nbv_pkg::NB_MAX];
    logic [63:0] pred_mem [nbv_pkg::NB_MAX];
    logic [63:0] olda_mem [nbv_pkg::NB_MAX];
    logic [63:0] newa_mem [nbv_pkg::NB_MAX];
    logic [63:0] pos_rd_reg, vel_rd_reg, pred_rd_reg, olda_rd_reg, newa_rd_reg;
    logic [31:0] mass_rd_reg;

    logic          accept, ld_we, pred_we, acc_we, cfg_we;
    logic [IW-1:0] rd_addr, i_addr, ld_addr;
    logic [63:0]   src_rd;

    nbv_pkg::au_req_t au_req;
    nbv_pkg::au_rsp_t au_rsp;
    logic [63:0]      au_a, au_b, au_res;
    logic             arith_st, call_go, call_done;

    logic signed [32:0] d_sel, asum;
    logic [32:0]        d_mag;
    logic signed [31:0] v_sel, ao_sel, an_sel, p_sel, acc_sel, new_val;
    logic signed [63:0] t_s, u_s, half_s, sum_s;
    logic [64:0]        d2_sum;

    nbv_arith_unit u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (au_req),
        .opa     (au_a),
        .opb     (au_b),
        .rsp     (au_rsp),
        .res     (au_res)
    );

    // register port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            nbv_pkg::REG_TIME_STEP:  prdata = time_step_reg;
            nbv_pkg::REG_GRAV_CONST: prdata = grav_const_reg;
            nbv_pkg::REG_MIN_DIST:   prdata = min_dist_reg;
            default:                 prdata = 32'h0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg  <= nbv_pkg::TIME_STEP_RST;
            grav_const_reg <= nbv_pkg::GRAV_CONST_RST;
            min_dist_reg   <= nbv_pkg::MIN_DIST_RST;
        end else if (cfg_we) begin
            case (paddr[3:2])
                nbv_pkg::REG_TIME_STEP:  time_step_reg  <= pwdata;
                nbv_pkg::REG_GRAV_CONST: grav_const_reg <= pwdata;
                nbv_pkg::REG_MIN_DIST:   min_dist_reg   <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // stores
    assign s_ready = (state_reg == nbv_pkg::ST_LOAD);
    assign accept  = s_valid && s_ready;
    assign ld_we   = accept && (count_reg < CW'(nbv_pkg::NB_MAX));
    assign ld_addr = count_reg[IW-1:0];
    assign i_addr  = i_reg[IW-1:0];
    assign rd_addr = (state_reg == nbv_pkg::ST_A_RDJ) ? j_reg[IW-1:0] : i_addr;
    assign pred_we = (state_reg == nbv_pkg::ST_P_WR);
    assign acc_we  = (state_reg == nbv_pkg::ST_A_WR);
    assign src_rd  = pass_reg ? pred_rd_reg : pos_rd_reg;

    always_ff @(posedge aclk) begin
        if (ld_we) begin
            pos_mem[ld_addr]  <= {s_pos_y, s_pos_x};
            vel_mem[ld_addr]  <= {s_vel_y, s_vel_x};
            mass_mem[ld_addr] <= s_mass;
        end
        if (pred_we) begin
            pred_mem[i_addr] <= {accy_reg, accx_reg};
        end
        if (acc_we && !pass_reg) begin
            olda_mem[i_addr] <= {accy_reg, accx_reg};
        end
        if (acc_we && pass_reg) begin
            newa_mem[i_addr] <= {accy_reg, accx_reg};
        end
        pos_rd_reg  <= pos_mem[rd_addr];
        vel_rd_reg  <= vel_mem[rd_addr];
        mass_rd_reg <= mass_mem[rd_addr];
        pred_rd_reg <= pred_mem[rd_addr];
        olda_rd_reg <= olda_mem[rd_addr];
        newa_rd_reg <= newa_mem[rd_addr];
    end

    // axis selection
    always_comb begin
        d_sel   = k_reg ? dy_reg : dx_reg;
        d_mag   = nbv_pkg::abs33(d_sel);
        v_sel   = k_reg ? rv_y_reg : rv_x_reg;
        ao_sel  = k_reg ? ro_y_reg : ro_x_reg;
        an_sel  = k_reg ? rn_y_reg : rn_x_reg;
        p_sel   = k_reg ? rp_y_reg : rp_x_reg;
        acc_sel = k_reg ? accy_reg : accx_reg;
        asum    = $signed({ao_sel[31], ao_sel}) + $signed({an_sel[31], an_sel});
        t_s     = $signed({1'b0, t_reg});
        u_s     = $signed({1'b0, u_reg});
        half_s  = $signed({2'b00, t_reg[62:1]});
        d2_sum  = {1'b0, sq_reg} + {1'b0, au_res};
    end

    // arithmetic unit operands
    always_comb begin
        au_a     = '0;
        au_b     = '0;
        arith_st = 1'b1;
        au_req.op = nbv_pkg::AU_MULQ;
        case (state_reg)
            nbv_pkg::ST_A_SQX: begin
                au_req.op = nbv_pkg::AU_MULF;
                au_a = 64'(nbv_pkg::abs33(dx_reg));
                au_b = 64'(nbv_pkg::abs33(dx_reg));
            end
            nbv_pkg::ST_A_SQY: begin
                au_req.op = nbv_pkg::AU_MULF;
                au_a = 64'(nbv_pkg::abs33(dy_reg));
                au_b = 64'(nbv_pkg::abs33(dy_reg));
            end
            nbv_pkg::ST_A_SQRT: begin
                au_req.op = nbv_pkg::AU_SQRT;
                au_a = d2_reg;
            end
            nbv_pkg::ST_A_GM: begin
                au_a = 64'(grav_const_reg);
                au_b = 64'(mj_reg);
            end
            nbv_pkg::ST_A_TERM: begin
                au_a = 64'(gm_reg);
                au_b = 64'(d_mag);
            end
            nbv_pkg::ST_A_DIV: begin
                au_req.op = nbv_pkg::AU_DIVQ;
                au_a = 64'(t_reg);
                au_b = 64'(dist_reg);
            end
            nbv_pkg::ST_P_V: begin
                au_a = 64'(nbv_pkg::abs32(v_sel));
                au_b = 64'(time_step_reg);
            end
            nbv_pkg::ST_P_A1: begin
                au_a = 64'(nbv_pkg::abs32(ao_sel));
                au_b = 64'(time_step_reg);
            end
            nbv_pkg::ST_P_A2: begin
                au_a = 64'(t_reg);
                au_b = 64'(time_step_reg);
            end
            nbv_pkg::ST_V_MUL: begin
                au_a = 64'(nbv_pkg::abs33(asum));
                au_b = 64'(time_step_reg);
            end
            default: begin
                arith_st = 1'b0;
            end
        endcase
        au_req.go = arith_st && !issued_reg;
    end

    assign call_go   = arith_st && !issued_reg;
    assign call_done = arith_st && issued_reg && au_rsp.done;

    // step sequencer
    always_comb begin
        state_next  = state_reg;
        issued_next = issued_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        pass_next   = pass_reg;
        k_next      = k_reg;
        dcnt_next   = dcnt_reg;
        rp_x_next   = rp_x_reg;
        rp_y_next   = rp_y_reg;
        rv_x_next   = rv_x_reg;
        rv_y_next   = rv_y_reg;
        ro_x_next   = ro_x_reg;
        ro_y_next   = ro_y_reg;
        rn_x_next   = rn_x_reg;
        rn_y_next   = rn_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        mj_next     = mj_reg;
        sq_next     = sq_reg;
        d2_next     = d2_reg;
        dist_next   = dist_reg;
        gm_next     = gm_reg;
        t_next      = t_reg;
        u_next      = u_reg;
        accx_next   = accx_reg;
        accy_next   = accy_reg;
        sum_s       = '0;
        new_val     = '0;
        if (call_go) begin
            issued_next = 1'b1;
        end
        if (call_done) begin
            issued_next = 1'b0;
        end
        case (state_reg)
            nbv_pkg::ST_LOAD: begin
                if (accept) begin
                    if (ld_we) begin
                        count_next = count_reg + 1'b1;
                    end
                    if (s_last_body) begin
                        n_next     = ld_we ? count_reg + 1'b1 : count_reg;
                        count_next = '0;
                        i_next     = '0;
                        pass_next  = 1'b0;
                        state_next = nbv_pkg::ST_A_RDI;
                    end
                end
            end
            nbv_pkg::ST_A_RDI: begin
                state_next = nbv_pkg::ST_A_LDI;
            end
            nbv_pkg::ST_A_LDI: begin
                rp_x_next  = $signed(src_rd[31:0]);
                rp_y_next  = $signed(src_rd[63:32]);
                accx_next  = '0;
                accy_next  = '0;
                j_next     = '0;
                state_next = nbv_pkg::ST_A_RDJ;
            end
            nbv_pkg::ST_A_RDJ: begin
                if (j_reg == n_reg) begin
                    state_next = nbv_pkg::ST_A_WR;
                end else if (j_reg == i_reg) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    state_next = nbv_pkg::ST_A_DIFF;
                end
            end
            nbv_pkg::ST_A_DIFF: begin
                dx_next    = $signed({src_rd[31], src_rd[31:0]}) - $signed({rp_x_reg[31], rp_x_reg});
                dy_next    = $signed({src_rd[63], src_rd[63:32]}) - $signed({rp_y_reg[31], rp_y_reg});
                mj_next    = mass_rd_reg;
                j_next     = j_reg + 1'b1;
                state_next = nbv_pkg::ST_A_SQX;
            end
            nbv_pkg::ST_A_SQX: begin
                if (call_done) begin
                    sq_next    = au_res;
                    state_next = nbv_pkg::ST_A_SQY;
                end
            end
            nbv_pkg::ST_A_SQY: begin
                if (call_done) begin
                    d2_next    = d2_sum[64] ? '1 : d2_sum[63:0];
                    state_next = nbv_pkg::ST_A_SQRT;
                end
            end
            nbv_pkg::ST_A_SQRT: begin
                if (call_done) begin
                    dist_next = au_res[31:0];
                    if (au_res[31:0] == 32'h0 || au_res[31:0] < min_dist_reg) begin
                        state_next = nbv_pkg::ST_A_RDJ;
                    end else begin
                        state_next = nbv_pkg::ST_A_GM;
                    end
                end
            end
            nbv_pkg::ST_A_GM: begin
                if (call_done) begin
                    gm_next    = au_res[47:0];
                    k_next     = 1'b0;
                    state_next = nbv_pkg::ST_A_TERM;
                end
            end
            nbv_pkg::ST_A_TERM: begin
                if (call_done) begin
                    t_next     = au_res[62:0];
                    dcnt_next  = '0;
                    state_next = nbv_pkg::ST_A_DIV;
                end
            end
            nbv_pkg::ST_A_DIV: begin
                if (call_done) begin
                    t_next = au_res[62:0];
                    if (dcnt_reg == 2'd2) begin
                        state_next = nbv_pkg::ST_A_ACC;
                    end else begin
                        dcnt_next = dcnt_reg + 2'd1;
                    end
                end
            end
            nbv_pkg::ST_A_ACC: begin
                sum_s   = nbv_pkg::sext64(acc_sel) + (d_sel[32] ? -t_s : t_s);
                new_val = nbv_pkg::sat32(sum_s);
                if (!k_reg) begin
                    accx_next  = new_val;
                    k_next     = 1'b1;
                    state_next = nbv_pkg::ST_A_TERM;
                end else begin
                    accy_next  = new_val;
                    state_next = nbv_pkg::ST_A_RDJ;
                end
            end
            nbv_pkg::ST_A_WR: begin
                if (i_reg + 1'b1 == n_reg) begin
                    i_next     = '0;
                    state_next = pass_reg ? nbv_pkg::ST_V_RD : nbv_pkg::ST_P_RD;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = nbv_pkg::ST_A_RDI;
                end
            end
            nbv_pkg::ST_P_RD: begin
                state_next = nbv_pkg::ST_P_LD;
            end
            nbv_pkg::ST_P_LD: begin
                rp_x_next  = $signed(pos_rd_reg[31:0]);
                rp_y_next  = $signed(pos_rd_reg[63:32]);
                rv_x_next  = $signed(vel_rd_reg[31:0]);
                rv_y_next  = $signed(vel_rd_reg[63:32]);
                ro_x_next  = $signed(olda_rd_reg[31:0]);
                ro_y_next  = $signed(olda_rd_reg[63:32]);
                k_next     = 1'b0;
                state_next = nbv_pkg::ST_P_V;
            end
            nbv_pkg::ST_P_V: begin
                if (call_done) begin
                    u_next     = au_res[62:0];
                    state_next = nbv_pkg::ST_P_A1;
                end
            end
            nbv_pkg::ST_P_A1: begin
                if (call_done) begin
                    t_next     = au_res[62:0];
                    state_next = nbv_pkg::ST_P_A2;
                end
            end
            nbv_pkg::ST_P_A2: begin
                if (call_done) begin
                    t_next     = au_res[62:0];
                    state_next = nbv_pkg::ST_P_SUM;
                end
            end
            nbv_pkg::ST_P_SUM: begin
                sum_s   = nbv_pkg::sext64(p_sel) + (v_sel[31] ? -u_s : u_s)
                        + (ao_sel[31] ? -half_s : half_s);
                new_val = nbv_pkg::sat32(sum_s);
                if (!k_reg) begin
                    accx_next  = new_val;
                    k_next     = 1'b1;
                    state_next = nbv_pkg::ST_P_V;
                end else begin
                    accy_next  = new_val;
                    state_next = nbv_pkg::ST_P_WR;
                end
            end
            nbv_pkg::ST_P_WR: begin
                if (i_reg + 1'b1 == n_reg) begin
                    i_next     = '0;
                    pass_next  = 1'b1;
                    state_next = nbv_pkg::ST_A_RDI;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = nbv_pkg::ST_P_RD;
                end
            end
            nbv_pkg::ST_V_RD: begin
                state_next = nbv_pkg::ST_V_LD;
            end
            nbv_pkg::ST_V_LD: begin
                rp_x_next  = $signed(pred_rd_reg[31:0]);
                rp_y_next  = $signed(pred_rd_reg[63:32]);
                rv_x_next  = $signed(vel_rd_reg[31:0]);
                rv_y_next  = $signed(vel_rd_reg[63:32]);
                ro_x_next  = $signed(olda_rd_reg[31:0]);
                ro_y_next  = $signed(olda_rd_reg[63:32]);
                rn_x_next  = $signed(newa_rd_reg[31:0]);
                rn_y_next  = $signed(newa_rd_reg[63:32]);
                k_next     = 1'b0;
                state_next = nbv_pkg::ST_V_MUL;
            end
            nbv_pkg::ST_V_MUL: begin
                if (call_done) begin
                    t_next     = au_res[62:0];
                    state_next = nbv_pkg::ST_V_SUM;
                end
            end
            nbv_pkg::ST_V_SUM: begin
                sum_s   = nbv_pkg::sext64(v_sel) + (asum[32] ? -half_s : half_s);
                new_val = nbv_pkg::sat32(sum_s);
                if (!k_reg) begin
                    accx_next  = new_val;
                    k_next     = 1'b1;
                    state_next = nbv_pkg::ST_V_MUL;
                end else begin
                    accy_next  = new_val;
                    state_next = nbv_pkg::ST_V_OUT;
                end
            end
            nbv_pkg::ST_V_OUT: begin
                if (m_ready) begin
                    if (i_reg + 1'b1 == n_reg) begin
                        state_next = nbv_pkg::ST_LOAD;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = nbv_pkg::ST_V_RD;
                    end
                end
            end
            default: begin
                state_next = nbv_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= nbv_pkg::ST_LOAD;
            issued_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        pass_reg <= pass_next;
        k_reg    <= k_next;
        dcnt_reg <= dcnt_next;
        rp_x_reg <= rp_x_next;
        rp_y_reg <= rp_y_next;
        rv_x_reg <= rv_x_next;
        rv_y_reg <= rv_y_next;
        ro_x_reg <= ro_x_next;
        ro_y_reg <= ro_y_next;
        rn_x_reg <= rn_x_next;
        rn_y_reg <= rn_y_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        mj_reg   <= mj_next;
        sq_reg   <= sq_next;
        d2_reg   <= d2_next;
        dist_reg <= dist_next;
        gm_reg   <= gm_next;
        t_reg    <= t_next;
        u_reg    <= u_next;
        accx_reg <= accx_next;
        accy_reg <= accy_next;
    end

    // result word
    assign m_valid       = (state_reg == nbv_pkg::ST_V_OUT);
    assign m_body_index  = 6'(i_reg);
    assign m_new_pos_x   = rp_x_reg;
    assign m_new_pos_y   = rp_y_reg;
    assign m_new_vel_x   = accx_reg;
    assign m_new_vel_y   = accy_reg;
    assign m_last_result = (i_reg + 1'b1 == n_reg);

endmodule
`default_nettype wire

// ===== hw/rtl/nbv_arith_unit.sv =====
// shared multi-cycle multiply, divide and square root unit
`default_nettype none
module nbv_arith_unit (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire nbv_pkg::au_req_t req,
    input  wire logic [63:0]    opa,
    input  wire logic [63:0]    opb,
    output nbv_pkg::au_rsp_t    rsp,
    output logic [63:0]         res
);

    nbv_pkg::au_op_t op_reg, op_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [63:0]     a_reg, a_next;
    logic [63:0]     b_reg, b_next;
    logic [127:0]    prod_reg, prod_next;
    logic [63:0]     pp_reg, pp_next;
    logic [79:0]     qr_reg, qr_next;
    logic [31:0]     rem_reg, rem_next;
    logic [63:0]     sx_reg, sx_next;
    logic [33:0]     srem_reg, srem_next;
    logic [31:0]     root_reg, root_next;

    logic [31:0]     ma, mb;
    logic [1:0]      pidx;
    logic [127:0]    pp_sh;
    logic [32:0]     r33;
    logic [35:0]     r36, tr36;
    logic [4:0]      last;

    assign rsp.done = done_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        pp_next   = pp_reg;
        qr_next   = qr_reg;
        rem_next  = rem_reg;
        sx_next   = sx_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        ma        = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        mb        = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pidx      = 2'(cnt_reg - 5'd1);
        r33       = '0;
        r36       = '0;
        tr36      = '0;
        case (pidx)
            2'd0:    pp_sh = {64'h0, pp_reg};
            2'd1:    pp_sh = {32'h0, pp_reg, 32'h0};
            2'd2:    pp_sh = {32'h0, pp_reg, 32'h0};
            default: pp_sh = {pp_reg, 64'h0};
        endcase
        case (op_reg)
            nbv_pkg::AU_DIVQ: last = nbv_pkg::DIV_LAST;
            nbv_pkg::AU_SQRT: last = nbv_pkg::SQRT_LAST;
            default:          last = nbv_pkg::MUL_LAST;
        endcase
        if (req.go && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = req.op;
            a_next    = opa;
            b_next    = opb;
            prod_next = '0;
            qr_next   = {1'b0, opa[62:0], 16'h0};
            rem_next  = '0;
            sx_next   = opa;
            srem_next = '0;
            root_next = '0;
        end else if (busy_reg) begin
            case (op_reg)
                nbv_pkg::AU_DIVQ: begin
                    for (int s = 0; s < nbv_pkg::DIV_BPC; s++) begin
                        r33     = {rem_next, qr_next[79]};
                        qr_next = {qr_next[78:0], 1'b0};
                        if (r33 >= {1'b0, b_reg[31:0]}) begin
                            rem_next   = 32'(r33 - {1'b0, b_reg[31:0]});
                            qr_next[0] = 1'b1;
                        end else begin
                            rem_next = r33[31:0];
                        end
                    end
                end
                nbv_pkg::AU_SQRT: begin
                    for (int s = 0; s < nbv_pkg::SQRT_BPC; s++) begin
                        r36     = {srem_next, sx_next[63:62]};
                        sx_next = {sx_next[61:0], 2'b00};
                        tr36    = {2'b00, root_next, 2'b01};
                        if (r36 >= tr36) begin
                            srem_next = 34'(r36 - tr36);
                            root_next = {root_next[30:0], 1'b1};
                        end else begin
                            srem_next = r36[33:0];
                            root_next = {root_next[30:0], 1'b0};
                        end
                    end
                end
                default: begin
                    if (cnt_reg < nbv_pkg::MUL_LAST) begin
                        pp_next = ma * mb;
                    end
                    if (cnt_reg != 5'd0) begin
                        prod_next = prod_reg + pp_sh;
                    end
                end
            endcase
            if (cnt_reg == last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 5'd1;
            end
        end
    end

    always_comb begin
        case (op_reg)
            nbv_pkg::AU_MULF: res = prod_reg[63:0];
            nbv_pkg::AU_MULQ: res = (|prod_reg[127:78]) ? {1'b0, nbv_pkg::MAG_CAP}
                                                         : {2'b00, prod_reg[77:16]};
            nbv_pkg::AU_DIVQ: res = (|qr_reg[79:62]) ? {1'b0, nbv_pkg::MAG_CAP}
                                                      : {2'b00, qr_reg[61:0]};
            nbv_pkg::AU_SQRT: res = {32'h0, root_reg};
            default:          res = prod_reg[63:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= nbv_pkg::AU_MULF;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        pp_reg   <= pp_next;
        qr_reg   <= qr_next;
        rem_reg  <= rem_next;
        sx_reg   <= sx_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/nbv_checker.sv =====
// port-level checks of the n-body verlet step, bound to the top level
`default_nettype none
module nbv_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_last_body,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_last_result,
    input wire logic [31:0] m_new_pos_x
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_pos_x))
        else $error("result word changed while stalled");

    a_no_load_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while results pending");

    a_last_starts_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_body |=> !s_ready && !m_valid)
        else $error("step did not start after last body");

    a_last_ends_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_result |=> s_ready && !m_valid)
        else $error("block not back to loading after last result");

    a_result_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_result |=> !m_valid && !s_ready)
        else $error("next result word without update");

endmodule

bind nbody_gravity_verlet_step nbv_checker u_nbv_checker (.*);
`default_nettype wire

// ===== sim/nbody_gravity_verlet_step_tb.sv =====
// testbench of the n-body verlet step: body stream in, predicted step results checked out
`timescale 1ns / 1ps
`default_nettype none
module nbody_gravity_verlet_step_tb;

    typedef struct {
        logic signed [31:0] px, py, vx, vy;
        logic [31:0]        mass;
        logic               last;
    } body_t;

    typedef struct {
        logic [5:0]         idx;
        logic signed [31:0] px, py, vx, vy;
        logic               last;
    } step_out_t;

    localparam logic [63:0] CAP = {1'b0, nbv_pkg::MAG_CAP};

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, s_ready;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_vel_x = '0, s_vel_y = '0;
    logic [31:0] s_mass = '0;
    logic s_last_body = 1'b0;
    logic m_valid, m_ready = 1'b0;
    logic [5:0] m_body_index;
    logic signed [31:0] m_new_pos_x, m_new_pos_y, m_new_vel_x, m_new_vel_y;
    logic m_last_result;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [nbv_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready;

    nbody_gravity_verlet_step u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [31:0] dt_q = nbv_pkg::TIME_STEP_RST, g_q = nbv_pkg::GRAV_CONST_RST;
    logic [31:0] rmin_q = nbv_pkg::MIN_DIST_RST;
    int          loaded = 0;
    longint      pos_st[nbv_pkg::NB_MAX][2], vel_st[nbv_pkg::NB_MAX][2];
    longint      prd_st[nbv_pkg::NB_MAX][2];
    longint      acc_old[nbv_pkg::NB_MAX][2], acc_new[nbv_pkg::NB_MAX][2];
    logic [31:0] mass_st[nbv_pkg::NB_MAX];

    body_t     bodies_q[$];
    step_out_t results_q[$];
    int        errors = 0;
    bit        burst = 1'b0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:78] != 0) return CAP;
        return p[79:16] > CAP ? CAP : p[79:16];
    endfunction

    function automatic longint smulq(input longint a, input logic [63:0] b);
        longint m;
        m = longint'(mulq(mag(a), b));
        return a < 0 ? -m : m;
    endfunction

    function automatic logic [63:0] divq(input logic [63:0] t, input logic [63:0] d);
        logic [63:0] q, r, res;
        logic [127:0] f;
        q = t / d;
        r = t % d;
        if (q >= (64'd1 << 46)) return CAP;
        f = {48'd0, r, 16'd0} / {64'd0, d};
        res = (q << 16) + f[63:0];
        return res > CAP ? CAP : res;
    endfunction

    function automatic logic [63:0] root(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // pass 0 uses loaded positions into acc_old, pass 1 predicted ones into acc_new
    function automatic void gravity_pass(input bit second, input int n);
        longint d[2], pi, pj, t;
        logic [63:0] sq0, sq1, d2, rdist, gm, m;
        for (int i = 0; i < n; i++) begin
            longint a[2];
            a[0] = 0;
            a[1] = 0;
            for (int j = 0; j < n; j++) begin
                if (i == j) continue;
                for (int k = 0; k < 2; k++) begin
                    pi = second ? prd_st[i][k] : pos_st[i][k];
                    pj = second ? prd_st[j][k] : pos_st[j][k];
                    d[k] = pj - pi;
                end
                sq0 = mag(d[0]) * mag(d[0]);
                sq1 = mag(d[1]) * mag(d[1]);
                d2 = sq0 + sq1;
                if (d2 < sq0) d2 = '1;
                rdist = root(d2);
                if (rdist == 0 || rdist < {32'd0, rmin_q}) continue;
                gm = ({32'd0, g_q} * {32'd0, mass_st[j]}) >> 16;
                for (int k = 0; k < 2; k++) begin
                    m = divq(divq(divq(mulq(gm, mag(d[k])), rdist), rdist), rdist);
                    t = d[k] < 0 ? -longint'(m) : longint'(m);
                    a[k] = sat32(a[k] + t);
                end
            end
            for (int k = 0; k < 2; k++) begin
                if (second) acc_new[i][k] = a[k];
                else acc_old[i][k] = a[k];
            end
        end
    endfunction

    function automatic void verlet_body(input body_t b);
        int n;
        longint s, nv[2];
        logic [63:0] dt;
        step_out_t o;
        dt = {32'd0, dt_q};
        if (loaded < nbv_pkg::NB_MAX) begin
            pos_st[loaded][0] = longint'(b.px);
            pos_st[loaded][1] = longint'(b.py);
            vel_st[loaded][0] = longint'(b.vx);
            vel_st[loaded][1] = longint'(b.vy);
            mass_st[loaded] = b.mass;
            loaded++;
        end
        if (!b.last) return;
        n = loaded;
        loaded = 0;
        gravity_pass(1'b0, n);
        for (int i = 0; i < n; i++)
            for (int k = 0; k < 2; k++) begin
                s = pos_st[i][k] + smulq(vel_st[i][k], dt);
                s = s + smulq(smulq(acc_old[i][k], dt), dt) / 2;
                prd_st[i][k] = sat32(s);
            end
        gravity_pass(1'b1, n);
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 2; k++)
                nv[k] = sat32(vel_st[i][k] + smulq(acc_old[i][k] + acc_new[i][k], dt) / 2);
            o.idx = 6'(i);
            o.px = prd_st[i][0][31:0];
            o.py = prd_st[i][1][31:0];
            o.vx = nv[0][31:0];
            o.vy = nv[1][31:0];
            o.last = (i + 1 == n);
            results_q.push_back(o);
        end
    endfunction

    // body driver
    int s_gap = 0;
    always @(posedge aclk) begin
        logic nv;
        body_t b;
        nv = s_valid;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                b.px = s_pos_x; b.py = s_pos_y; b.vx = s_vel_x; b.vy = s_vel_y;
                b.mass = s_mass; b.last = s_last_body;
                verlet_body(b);
                nv = 1'b0;
                s_gap = burst ? 0 : $urandom_range(0, 17);
            end
            if (!nv) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (bodies_q.size() > 0) begin
                    b = bodies_q.pop_front();
                    s_pos_x <= b.px; s_pos_y <= b.py; s_vel_x <= b.vx; s_vel_y <= b.vy;
                    s_mass <= b.mass; s_last_body <= b.last;
                    nv = 1'b1;
                end
            end
        end
        s_valid <= nv;
    end

    // result monitor
    int m_stall = 0;
    always @(posedge aclk) begin
        step_out_t w;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (results_q.size() == 0) begin
                    report("unexpected word", m_body_index, 0);
                end else begin
                    w = results_q.pop_front();
                    if (m_body_index !== w.idx) report("body_index", m_body_index, w.idx);
                    if (m_new_pos_x !== w.px) report("new_pos_x", m_new_pos_x, w.px);
                    if (m_new_pos_y !== w.py) report("new_pos_y", m_new_pos_y, w.py);
                    if (m_new_vel_x !== w.vx) report("new_vel_x", m_new_vel_x, w.vx);
                    if (m_new_vel_y !== w.vy) report("new_vel_y", m_new_vel_y, w.vy);
                    if (m_last_result !== w.last) report("last_result", m_last_result, w.last);
                end
                m_stall = burst ? 0 : $urandom_range(0, 17);
            end
            if (m_stall > 0) begin
                m_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            nbv_pkg::REG_TIME_STEP:  dt_q = val;
            nbv_pkg::REG_GRAV_CONST: g_q = val;
            nbv_pkg::REG_MIN_DIST:   rmin_q = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] dt, input logic [31:0] g, input logic [31:0] r);
        reg_write(nbv_pkg::REG_TIME_STEP, dt);
        reg_write(nbv_pkg::REG_GRAV_CONST, g);
        reg_write(nbv_pkg::REG_MIN_DIST, r);
    endtask

    task automatic push_body(input logic [31:0] px, py, vx, vy, m, input logic last);
        body_t b;
        b.px = px; b.py = py; b.vx = vx; b.vy = vy; b.mass = m; b.last = last;
        bodies_q.push_back(b);
    endtask

    function automatic logic [31:0] near_val();
        return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endfunction

    // one cluster of n bodies; wide ones use the full field range
    task automatic push_cluster(input int n, input bit wide);
        for (int i = 0; i < n; i++) begin
            if (wide)
                push_body($urandom, $urandom, $urandom, $urandom, $urandom, i == n - 1);
            else
                push_body(near_val(), near_val(), near_val(), near_val(),
                          $urandom_range(0, 4 << 16), i == n - 1);
        end
    endtask

    task automatic drain();
        while (bodies_q.size() > 0 || s_valid || results_q.size() > 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    initial begin
        int left, n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // single body, extreme fields
        push_body(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, '1, 1'b1);
        // coincident pair is skipped
        push_body(32'h0001_0000, 32'h0002_0000, 0, 0, 32'h0002_0000, 1'b0);
        push_body(32'h0001_0000, 32'h0002_0000, 0, 0, 32'h0002_0000, 1'b1);
        // far-apart extremes
        push_body(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, '1, 1'b0);
        push_body(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, '1, 1'b0);
        push_body(0, 0, 0, 0, 0, 1'b1);
        // pair closer than min_distance
        push_body(0, 0, 32'h0000_1000, 0, 32'h0001_0000, 1'b0);
        push_body(0, 32'h0000_0000, 0, 0, 32'h0001_0000, 1'b0);
        push_body(0, 1, 0, 0, 32'h0001_0000, 1'b0);
        push_body(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 1'b1);
        drain();

        set_regs(32'h0001_0000, '1, 0);
        push_body(0, 0, 0, 0, '1, 1'b0);
        push_body(0, 0, 0, 0, '1, 1'b0);
        push_body(32'h0000_8000, 32'hffff_8000, 0, 0, '1, 1'b1);
        push_cluster(3, 1'b1);
        drain();

        set_regs('1, 32'h0000_1000, '1);
        push_cluster(3, 1'b0);
        push_cluster(2, 1'b1);
        drain();

        set_regs(0, nbv_pkg::GRAV_CONST_RST, nbv_pkg::MIN_DIST_RST);
        push_cluster(2, 1'b0);
        drain();

        // too many bodies: extras dropped, last flag still starts the step
        set_regs(nbv_pkg::TIME_STEP_RST, nbv_pkg::GRAV_CONST_RST, 32'h0000_0100);
        burst = 1'b1;
        push_cluster(nbv_pkg::NB_MAX + 2, 1'b0);
        drain();
        burst = 1'b0;

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_regs(nbv_pkg::TIME_STEP_RST, nbv_pkg::GRAV_CONST_RST,
                            nbv_pkg::MIN_DIST_RST);
                1: set_regs($urandom_range(0, 1 << 16), $urandom_range(0, 8 << 16),
                            $urandom_range(0, 1 << 12));
                2: set_regs($urandom, $urandom, $urandom_range(0, 3));
                3: set_regs(0, '1, 0);
                default: set_regs($urandom_range(1, 4096), $urandom, $urandom_range(0, 1 << 16));
            endcase
            burst = (ph == 2);
            left = 42;
            while (left > 0) begin
                n = $urandom_range(1, 6);
                if (n > left) n = left;
                push_cluster(n, $urandom_range(0, 3) == 0);
                left -= n;
            end
            drain();
        end

        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
